// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define BSR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define BSR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, checked through reset
`define BSR_ASSERT_NXT_ALL(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bsr_pkg.sv =====
// Shared constants, codes and types of the backup store hash engine
`timescale 1ns / 1ps
package bsr_pkg;

  localparam int unsigned STORE_BYTES = 131072;
  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam int LEN_W = $clog2(STORE_BYTES + 1);
  localparam int LIMIT_W = 18;
  localparam logic [LIMIT_W-1:0] STORE_LIMIT = LIMIT_W'(STORE_BYTES);

  localparam logic [31:0] HASH_BASIS = 32'h811C9DC5;
  localparam logic [31:0] HASH_PRIME = 32'h01000193;
  localparam logic [7:0] BLANK_BYTE = 8'hFF;

  localparam logic [2:0] REQ_ARM      = 3'd0;
  localparam logic [2:0] REQ_DISARM   = 3'd1;
  localparam logic [2:0] REQ_WRITE    = 3'd2;
  localparam logic [2:0] REQ_ROLLBACK = 3'd3;
  localparam logic [2:0] REQ_BASELINE = 3'd4;
  localparam logic [2:0] REQ_FINISH   = 3'd5;
  localparam logic [2:0] REQ_QUERY    = 3'd6;

  localparam logic [3:0] Q_ARMED     = 4'd0;
  localparam logic [3:0] Q_APPLIED   = 4'd1;
  localparam logic [3:0] Q_KIND      = 4'd2;
  localparam logic [3:0] Q_BASE_HASH = 4'd3;
  localparam logic [3:0] Q_EXIT_HASH = 4'd4;
  localparam logic [3:0] Q_MODIFIED  = 4'd5;
  localparam logic [3:0] Q_ROLLBACKS = 4'd6;
  localparam logic [3:0] Q_PREFIX    = 4'd7;
  localparam logic [3:0] Q_NON_BLANK = 4'd8;

  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_NEW      = 2'd1;
  localparam logic [1:0] KIND_RESTORED = 2'd2;

  typedef enum logic [1:0] {
    MODE_HASH,
    MODE_COUNT,
    MODE_FILL
  } walk_mode_t;

  typedef struct packed {
    logic             start;
    walk_mode_t       mode;
    logic [LEN_W-1:0] len;
  } walk_cmd_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } walk_stat_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== rtl/bsr_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module bsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bsr_walk.sv =====
// Store walker: one pass for FNV-1a hash, non-blank count or blank fill
`timescale 1ns / 1ps
module bsr_walk import bsr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  walk_cmd_t  cmd,
  input  logic [7:0] rdata,
  output walk_stat_t stat,
  output mem_req_t   mem
);

  logic             busy;
  walk_mode_t       mode;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] cnt;
  logic             rd_vld;
  logic [31:0]      acc;
  logic             issue;
  logic [31:0]      hash_step;
  logic [31:0]      count_step;

  always_comb begin
    issue       = busy && (cnt != len);
    mem.we      = issue && (mode == MODE_FILL);
    mem.waddr   = cnt[ADDR_W-1:0];
    mem.raddr   = cnt[ADDR_W-1:0];
    stat.done   = busy && !issue && !rd_vld;
    stat.result = acc;
    hash_step   = (acc ^ {24'd0, rdata}) * HASH_PRIME;
    count_step  = acc + {31'd0, (rdata != BLANK_BYTE)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b1;
      mode   <= MODE_FILL;
      len    <= LEN_W'(STORE_BYTES);
      cnt    <= '0;
      rd_vld <= 1'b0;
      acc    <= '0;
    end else begin
      rd_vld <= issue && (mode != MODE_FILL);
      if (cmd.start) begin
        busy <= 1'b1;
        mode <= cmd.mode;
        len  <= cmd.len;
        cnt  <= '0;
        acc  <= (cmd.mode == MODE_HASH) ? HASH_BASIS : 32'd0;
      end else begin
        if (issue) begin
          cnt <= cnt + 1'b1;
        end
        if (stat.done) begin
          busy <= 1'b0;
        end
        if (rd_vld) begin
          acc <= (mode == MODE_HASH) ? hash_step : count_step;
        end
      end
    end
  end

endmodule

// ===== rtl/backup_store_restore_hash_engine.sv =====
// Top level: backup byte store with restore controller and FNV-1a hashing
// Arm, disarm, write, unknown requests, register and zero-length queries: result next cycle.
// Baseline, finish, nonzero prefix hash or non-blank count, modified query with a baseline but no exit hash:
// one store walk of N bytes at one byte per cycle; a rollback walk fills the store with 0xFF.
// N = STORE_BYTES or the clamped length_limit; one request in flight at a time.
// Reset: fill all STORE_BYTES entries with 0xFF, requests stalled.
`timescale 1ns / 1ps
module backup_store_restore_hash_engine import bsr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [2:0]  req_type,
  input  logic [16:0] write_offset,
  input  logic [7:0]  write_data,
  input  logic [17:0] region_limit,
  input  logic [17:0] length_limit,
  input  logic [1:0]  baseline_kind,
  input  logic [3:0]  query_select,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [31:0] reply_value,
  output logic        accepted
);

  typedef enum logic [2:0] {
    ST_INIT = 3'b001,
    ST_IDLE = 3'b010,
    ST_WALK = 3'b100
  } state_t;

  state_t             state;
  logic               armed;
  logic [31:0]        applied_count;
  logic [31:0]        rollback_count;
  logic [1:0]         base_kind;
  logic [31:0]        base_hash;
  logic [31:0]        exit_hash;
  logic               exit_taken;
  logic [2:0]         pend_type;
  logic [3:0]         pend_sel;

  logic               take;
  logic [LIMIT_W-1:0] region_c;
  logic [LIMIT_W-1:0] length_c;
  logic [LEN_W-1:0]   len_c;
  logic               wr_ok;
  logic               wr_hit;
  logic [1:0]         kind_rec;
  logic               go_walk;
  logic [31:0]        imm_reply;
  logic [31:0]        fin_reply;
  walk_cmd_t          cmd;
  walk_stat_t         stat;
  mem_req_t           mem;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [7:0]         ram_wdata;
  logic [7:0]         ram_rdata;

  assign req_stall = (state != ST_IDLE) || (rsp_valid && rsp_stall);
  assign take      = req_valid && !req_stall;
  assign region_c  = (region_limit > STORE_LIMIT) ? STORE_LIMIT : region_limit;
  assign length_c  = (length_limit > STORE_LIMIT) ? STORE_LIMIT : length_limit;
  assign len_c     = length_c[LEN_W-1:0];
  assign wr_ok     = armed && (region_c != '0) && ({1'b0, write_offset} < region_c);
  assign wr_hit    = take && (req_type == REQ_WRITE) && wr_ok;
  assign kind_rec  = (baseline_kind == KIND_NEW || baseline_kind == KIND_RESTORED) ?
                     baseline_kind : KIND_NONE;

  assign ram_we    = wr_hit || mem.we;
  assign ram_waddr = wr_hit ? write_offset[ADDR_W-1:0] : mem.waddr;
  assign ram_wdata = wr_hit ? write_data : BLANK_BYTE;

  always_comb begin
    cmd       = '0;
    cmd.mode  = MODE_HASH;
    cmd.len   = LEN_W'(STORE_BYTES);
    imm_reply = '0;
    go_walk   = 1'b0;
    case (req_type)
      REQ_ROLLBACK: begin
        go_walk  = 1'b1;
        cmd.mode = MODE_FILL;
      end
      REQ_BASELINE, REQ_FINISH: begin
        go_walk = 1'b1;
      end
      REQ_QUERY: begin
        case (query_select)
          Q_ARMED:     imm_reply = {31'd0, armed};
          Q_APPLIED:   imm_reply = applied_count;
          Q_KIND:      imm_reply = {30'd0, base_kind};
          Q_BASE_HASH: imm_reply = base_hash;
          Q_EXIT_HASH: imm_reply = exit_hash;
          Q_MODIFIED: begin
            if (base_kind == KIND_NONE) begin
              imm_reply = '0;
            end else if (exit_taken) begin
              imm_reply = {31'd0, (exit_hash != base_hash)};
            end else begin
              go_walk = 1'b1;
            end
          end
          Q_ROLLBACKS: imm_reply = rollback_count;
          Q_PREFIX: begin
            if (len_c != '0) begin
              go_walk = 1'b1;
              cmd.len = len_c;
            end
          end
          Q_NON_BLANK: begin
            if (len_c != '0) begin
              go_walk  = 1'b1;
              cmd.mode = MODE_COUNT;
              cmd.len  = len_c;
            end
          end
          default: imm_reply = '0;
        endcase
      end
      default: ;
    endcase
    cmd.start = take && go_walk;
  end

  always_comb begin
    fin_reply = '0;
    if (pend_type == REQ_QUERY) begin
      if (pend_sel == Q_MODIFIED) begin
        fin_reply = {31'd0, (stat.result != base_hash)};
      end else begin
        fin_reply = stat.result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_INIT;
      armed          <= 1'b0;
      applied_count  <= '0;
      rollback_count <= '0;
      base_kind      <= KIND_NONE;
      base_hash      <= '0;
      exit_hash      <= '0;
      exit_taken     <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && !(take && !go_walk)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_INIT: begin
          if (stat.done) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (take) begin
            case (req_type)
              REQ_ARM: armed <= 1'b1;
              REQ_DISARM: begin
                armed          <= 1'b0;
                applied_count  <= '0;
                rollback_count <= '0;
                base_kind      <= KIND_NONE;
                base_hash      <= '0;
                exit_hash      <= '0;
                exit_taken     <= 1'b0;
              end
              REQ_WRITE: begin
                if (wr_ok) begin
                  applied_count <= applied_count + 32'd1;
                end
              end
              REQ_ROLLBACK: begin
                applied_count  <= '0;
                rollback_count <= rollback_count + 32'd1;
              end
              REQ_BASELINE: begin
                base_kind  <= kind_rec;
                exit_hash  <= '0;
                exit_taken <= 1'b0;
              end
              default: ;
            endcase
            if (go_walk) begin
              state <= ST_WALK;
            end else begin
              rsp_valid <= 1'b1;
            end
          end
        end
        ST_WALK: begin
          if (stat.done) begin
            state     <= ST_IDLE;
            rsp_valid <= 1'b1;
            if (pend_type == REQ_BASELINE) begin
              base_hash <= stat.result;
            end
            if (pend_type == REQ_FINISH ||
                (pend_type == REQ_QUERY && pend_sel == Q_MODIFIED)) begin
              exit_hash  <= stat.result;
              exit_taken <= 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && take) begin
      pend_type   <= req_type;
      pend_sel    <= query_select;
      reply_value <= imm_reply;
      accepted    <= (req_type == REQ_WRITE) && wr_ok;
    end else if (state == ST_WALK && stat.done) begin
      reply_value <= fin_reply;
      accepted    <= 1'b0;
    end
  end

  bsr_walk u_walk (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .rdata (ram_rdata),
    .stat  (stat),
    .mem   (mem)
  );

  bsr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (mem.raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== rtl/bsr_checker.sv =====
// Port-level checks of the backup store hash engine and their bind
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bsr_checker import bsr_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_stall,
  input logic [2:0]  req_type,
  input logic [16:0] write_offset,
  input logic [7:0]  write_data,
  input logic [17:0] region_limit,
  input logic [17:0] length_limit,
  input logic [1:0]  baseline_kind,
  input logic [3:0]  query_select,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic [31:0] reply_value,
  input logic        accepted
);

  `BSR_ASSERT_IMP(a_acc_zero, clk, rst, rsp_valid && accepted, reply_value == 32'd0, "stored write carries a nonzero reply")
  `BSR_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(reply_value) && $stable(accepted), "stalled result changed")
  `BSR_ASSERT_IMP(a_back_press, clk, rst, rsp_valid && rsp_stall, req_stall, "request taken while result is stalled")
  `BSR_ASSERT_NXT(a_refused_write, clk, rst, req_valid && !req_stall && req_type == REQ_WRITE && region_limit == 18'd0, rsp_valid && !accepted, "write outside an empty region was not refused")
  `BSR_ASSERT_NXT_ALL(a_reset_quiet, clk, rst, !rsp_valid, "result shown after reset")

endmodule

bind backup_store_restore_hash_engine bsr_checker u_bsr_checker (.*);
